// ===== rtl/rnt_pkg.sv =====
// Package for the radio neighbor table: codes, entry record, item types.
// No dependencies.
package rnt_pkg;

  localparam int MacW = 48;
  localparam int TimeW = 32;
  localparam int CfgW = 32;

  localparam logic [2:0] FUNC_TOUCH  = 3'd0;
  localparam logic [2:0] FUNC_USED   = 3'd1;
  localparam logic [2:0] FUNC_FAIL   = 3'd2;
  localparam logic [2:0] FUNC_EXPIRE = 3'd3;
  localparam logic [2:0] FUNC_COUNT  = 3'd4;
  localparam logic [2:0] FUNC_LOOKUP = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_ARG  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic CFG_FAIL_THRESHOLD = 1'b0;
  localparam logic CFG_TIMEOUT_MS     = 1'b1;

  localparam logic [7:0] FAIL_MAX = 8'd255;

  typedef struct packed {
    logic [MacW-1:0]  mac;
    logic signed [7:0] sig_avg;
    logic signed [7:0] sig_last;
    logic [TimeW-1:0] seen;
    logic [TimeW-1:0] used;
    logic [7:0]       failures;
    logic             active;
  } entry_t;

  typedef struct packed {
    logic [2:0]        func;
    logic [MacW-1:0]   mac;
    logic signed [7:0] rssi;
    logic [TimeW-1:0]  now_ms;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [4:0]        number;
    logic signed [7:0] sig_avg;
    logic signed [7:0] sig_last;
    logic [7:0]        fail_count;
    logic              active;
    logic [TimeW-1:0]  heard_ms;
    logic [TimeW-1:0]  fwd_ms;
  } rsp_t;

  function automatic logic signed [7:0] smooth(input logic signed [7:0] avg,
                                               input logic signed [7:0] x);
    logic signed [10:0] s;
    logic signed [10:0] q;
    begin
      s = 11'(avg) * 11'sd3 + 11'(x);
      q = (s < 0) ? -((-s) >>> 2) : (s >>> 2);
      return q[7:0];
    end
  endfunction

endpackage

// ===== rtl/rnt_if.sv =====
// Valid/ready channel carrying one payload.
// Depends on nothing; the payload type is a parameter.
interface rnt_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/rnt_cell.sv =====
// One table slot of the circular row: holds an entry and passes it onward.
// Depends on rnt_pkg.
module rnt_cell (
  input  logic             clk_i,
  input  logic             step_i,
  input  rnt_pkg::entry_t  prev_i,
  output rnt_pkg::entry_t  entry_o
);
  import rnt_pkg::*;
  entry_t entry_q;
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      entry_q <= prev_i;
    end
  end
  assign entry_o = entry_q;
endmodule

// ===== rtl/radio_neighbor_table_core.sv =====
// Radio neighbor table top level: control sequencer over a rotating row of cells.
// Depends on rnt_pkg, rnt_if, rnt_cell.
//
// channel   dir  payload
// req       in   func, mac, rssi, now_ms
// rsp       out  status, number, entry fields of lookup
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i
//
// The row rotates once through the head cell, one entry a cycle matched, updated,
// counted or dropped; the scan then goes to the done state, which loads the result
// into the output register. Expire first passes through an align state that
// rotates survivors into place.
// Reset clears the count and control; the entries hold no reset.
// A result waits in the output register; the next item is taken once it leaves.
module radio_neighbor_table_core #(
  parameter int ENTRIES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_idx_i,
  input  logic [rnt_pkg::CfgW-1:0] cfg_data_i,
  rnt_if.sink   req,
  rnt_if.source rsp
);
  import rnt_pkg::*;

  localparam int CntW = $clog2(ENTRIES + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DONE  = 2'd2;
  localparam logic [1:0] S_ALIGN = 2'd3;

  logic [7:0]       thr_q;
  logic [TimeW-1:0] tmo_q;
  logic [1:0]       state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  pos_q, pos_d;
  logic [CntW-1:0]  keep_q, keep_d;
  logic [4:0]       num_q, num_d;
  logic             found_q, found_d;
  req_t             req_q;
  entry_t           hit_q, hit_d;
  rsp_t             rsp_q, rsp_d;
  logic             rsp_valid_q;

  entry_t cell_in [ENTRIES];
  entry_t cell_out [ENTRIES];
  logic [ENTRIES-1:0] cell_step;
  logic   step;
  entry_t head, head_new;
  logic   live, match, expired, drop;
  logic [TimeW-1:0] age;
  logic [CntW-1:0]  rem;

  assign req.ready = (state_q == S_IDLE) && !rsp_valid_q;
  assign rem = count_q - keep_q;
  assign step = (state_q == S_SCAN) || ((state_q == S_ALIGN) && (pos_q != rem));

  // Drop at the head: cells from the scan position up advance, the rest hold.
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    assign cell_step[g] = step && (!drop || (CntW'(g) >= pos_q));
    rnt_cell u_cell (.clk_i(clk_i), .step_i(cell_step[g]), .prev_i(cell_in[g]),
                     .entry_o(cell_out[g]));
    if (g > 0) begin : g_link
      assign cell_in[g] = cell_out[g-1];
    end
  end
  assign head = cell_out[ENTRIES-1];
  assign cell_in[0] = head_new;

  always_comb begin
    live = pos_q < count_q;
    match = live && (req_q.mac != '0) && (head.mac == req_q.mac);
    age = req_q.now_ms - head.seen;
    expired = age > tmo_q;
    drop = (state_q == S_SCAN) && (req_q.func == FUNC_EXPIRE) && live && expired;
    head_new = head;
    state_d = state_q;
    count_d = count_q;
    pos_d = pos_q;
    keep_d = keep_q;
    num_d = num_q;
    found_d = found_q;
    hit_d = hit_q;
    case (state_q)
      S_IDLE: begin
        if (req.valid && req.ready) begin
          state_d = S_SCAN;
          pos_d = '0;
          keep_d = '0;
          num_d = '0;
          found_d = 1'b0;
        end
      end
      S_SCAN: begin
        pos_d = pos_q + 1'b1;
        if (pos_q == CntW'(ENTRIES - 1)) begin
          pos_d = '0;
          state_d = (req_q.func == FUNC_EXPIRE) ? S_ALIGN : S_DONE;
        end
        if (!live && pos_q == count_q && req_q.func == FUNC_TOUCH && !found_q
            && req_q.mac != '0) begin
          head_new.mac = req_q.mac;
          head_new.sig_avg = req_q.rssi;
          head_new.sig_last = req_q.rssi;
          head_new.seen = req_q.now_ms;
          head_new.used = req_q.now_ms;
          head_new.failures = '0;
          head_new.active = 1'b1;
        end
        if (match) begin
          found_d = 1'b1;
          hit_d = head;
        end
        case (req_q.func)
          FUNC_TOUCH: if (match) begin
            head_new.sig_avg = head.active ? smooth(head.sig_avg, req_q.rssi)
                                           : req_q.rssi;
            head_new.sig_last = req_q.rssi;
            head_new.seen = req_q.now_ms;
            head_new.failures = '0;
            head_new.active = 1'b1;
          end
          FUNC_USED: if (match) begin
            head_new.used = req_q.now_ms;
          end
          FUNC_FAIL: if (match) begin
            if (head.failures != FAIL_MAX) begin
              head_new.failures = head.failures + 8'd1;
            end
            if (head_new.failures >= thr_q) begin
              head_new.active = 1'b0;
            end
          end
          FUNC_EXPIRE: if (live) begin
            if (expired) begin
              num_d = num_q + 5'd1;
            end else begin
              keep_d = keep_q + 1'b1;
            end
          end
          FUNC_COUNT: if (live && head.active) begin
            num_d = num_q + 5'd1;
          end
          default: ;
        endcase
      end
      S_ALIGN: begin
        if (pos_q == rem) begin
          state_d = S_DONE;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
        if (req_q.func == FUNC_TOUCH && !found_q && req_q.mac != '0
            && count_q < CntW'(ENTRIES)) begin
          count_d = count_q + 1'b1;
        end
        if (req_q.func == FUNC_EXPIRE) begin
          count_d = keep_q;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    rsp_d = '0;
    case (req_q.func)
      FUNC_TOUCH: begin
        if (req_q.mac == '0) rsp_d.status = ST_BAD_ARG;
        else if (!found_q && count_q >= CntW'(ENTRIES)) rsp_d.status = ST_FULL;
      end
      FUNC_USED, FUNC_FAIL: if (!found_q) rsp_d.status = ST_NOTFOUND;
      FUNC_EXPIRE, FUNC_COUNT: rsp_d.number = num_q;
      FUNC_LOOKUP: begin
        if (!found_q) begin
          rsp_d.status = ST_NOTFOUND;
        end else begin
          rsp_d.sig_avg = hit_q.sig_avg;
          rsp_d.sig_last = hit_q.sig_last;
          rsp_d.fail_count = hit_q.failures;
          rsp_d.active = hit_q.active;
          rsp_d.heard_ms = hit_q.seen;
          rsp_d.fwd_ms = hit_q.used;
        end
      end
      default: rsp_d.status = ST_BAD_ARG;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      thr_q <= 8'd3;
      tmo_q <= 32'd10000;
      rsp_valid_q <= 1'b0;
      pos_q <= '0;
      keep_q <= '0;
      num_q <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pos_q <= pos_d;
      keep_q <= keep_d;
      num_q <= num_d;
      found_q <= found_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_FAIL_THRESHOLD) thr_q <= cfg_data_i[7:0];
        else tmo_q <= cfg_data_i[TimeW-1:0];
      end
      if (state_q == S_DONE) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
    if (req.valid && req.ready) begin
      req_q <= req.data;
    end
    if (state_q == S_DONE) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp.valid = rsp_valid_q;
  assign rsp.data = rsp_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(ENTRIES)) else $error("entry count above depth");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !req.ready) else $error("accept while busy");
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> rsp.valid) else $error("result lost");
endmodule
